// ===== sv/snr_pkg.sv =====
package snr_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_LOOKUP   = 2'd1;
  localparam logic [1:0] CMD_SPARE0   = 2'd2;
  localparam logic [1:0] CMD_SPARE1   = 2'd3;

  typedef enum logic [2:0] {
    STATUS_REGISTERED  = 3'd0,
    STATUS_REG_FAILED  = 3'd1,
    STATUS_FOUND       = 3'd2,
    STATUS_NO_MATCH    = 3'd3,
    STATUS_BAD_COMMAND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] name;
    logic [31:0] handle;
    logic [31:0] owner;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ===== sv/snr_req_if.sv =====
interface snr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] service_name;
  logic [31:0] service_handle;
  logic [31:0] requester_id;

  modport source (output valid, command, service_name, service_handle, requester_id,
                  input ready);
  modport sink   (input valid, command, service_name, service_handle, requester_id,
                  output ready);
endinterface

// ===== sv/snr_rsp_if.sv =====
interface snr_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] found_handle;
  logic [31:0] found_owner;

  modport source (output valid, status, found_handle, found_owner, input ready);
  modport sink   (input valid, status, found_handle, found_owner, output ready);
endinterface

// ===== sv/snr_ram.sv =====
module snr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== sv/service_name_registry_unit.sv =====
// channel  dir  handshake     word
// req_i    in   valid/ready   command, service_name, service_handle, requester_id
// rsp_o    out  valid/ready   status, found_handle, found_owner
//
// one request at a time; between accept and result, register and lookup walk
// the table ram one entry a cycle
// unsupported commands go straight to the done state, no table walk
// reset clears the per-entry valid bits at once, so no clearing pass is needed
// a result waits in the output register; the next request is taken meanwhile
// and its result stalls in the done state until the register is free
module service_name_registry_unit (
  input  logic clk_i,
  input  logic rst_ni,
  snr_req_if.sink   req_i,
  snr_rsp_if.source rsp_o
);

  localparam int unsigned N     = snr_pkg::TABLE_ENTRIES;
  localparam int unsigned IDX_W = snr_pkg::IDX_W;
  localparam int unsigned CNT_W = snr_pkg::CNT_W;

  snr_pkg::state_e state_q, state_d;

  logic [1:0]  cmd_q;
  logic [31:0] name_q, handle_q, owner_q;

  logic [CNT_W-1:0] rd_cnt_q;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic [N-1:0]     valid_q;

  logic             hit_q;
  logic [31:0]      hit_handle_q, hit_owner_q;
  logic             free_found_q;
  logic [IDX_W-1:0] free_idx_q;

  logic             rsp_valid_q;
  snr_pkg::status_e rsp_status_q;
  logic [31:0]      rsp_handle_q, rsp_owner_q;

  logic             accept;
  logic             rd_en;
  logic             last_cmp;
  logic             rsp_free;
  logic             finish;
  logic             reg_ok;
  logic             ram_we;
  snr_pkg::entry_t  ram_wdata;
  snr_pkg::entry_t  ram_rdata;
  logic [snr_pkg::ENTRY_W-1:0] ram_rdata_raw;

  assign ram_rdata = snr_pkg::entry_t'(ram_rdata_raw);
  assign ram_wdata = '{name: name_q, handle: handle_q, owner: owner_q};

  assign last_cmp = cmp_vld_q && (cmp_idx_q == IDX_W'(N - 1));
  assign rsp_free = !rsp_valid_q || rsp_o.ready;
  assign reg_ok   = (cmd_q == snr_pkg::CMD_REGISTER) && (handle_q != 32'd0)
                    && !hit_q && free_found_q;

  // control outputs
  always_comb begin
    req_i.ready = 1'b0;
    rd_en       = 1'b0;
    finish      = 1'b0;
    ram_we      = 1'b0;
    case (state_q)
      snr_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
      end
      snr_pkg::ST_SCAN: begin
        rd_en = rd_cnt_q < CNT_W'(N);
      end
      snr_pkg::ST_DONE: begin
        finish = rsp_free;
        ram_we = rsp_free && reg_ok;
      end
      default: begin
        req_i.ready = 1'b0;
      end
    endcase
  end

  assign accept = req_i.valid && req_i.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      snr_pkg::ST_IDLE: begin
        if (accept) begin
          if ((req_i.command == snr_pkg::CMD_REGISTER) ||
              (req_i.command == snr_pkg::CMD_LOOKUP)) begin
            state_d = snr_pkg::ST_SCAN;
          end else begin
            state_d = snr_pkg::ST_DONE;
          end
        end
      end
      snr_pkg::ST_SCAN: begin
        if (last_cmp) begin
          state_d = snr_pkg::ST_DONE;
        end
      end
      snr_pkg::ST_DONE: begin
        if (finish) begin
          state_d = snr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = snr_pkg::ST_IDLE;
      end
    endcase
  end

  snr_ram #(
    .WIDTH (snr_pkg::ENTRY_W),
    .DEPTH (N)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx_q),
    .wdata_i (ram_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_cnt_q[IDX_W-1:0]),
    .rdata_o (ram_rdata_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= snr_pkg::ST_IDLE;
      rd_cnt_q     <= '0;
      cmp_vld_q    <= 1'b0;
      valid_q      <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= rd_en;
      if (accept) begin
        rd_cnt_q     <= '0;
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
      end
      if (rd_en) begin
        rd_cnt_q <= rd_cnt_q + CNT_W'(1);
      end
      if (cmp_vld_q) begin
        if (valid_q[cmp_idx_q] && (ram_rdata.name == name_q)) begin
          hit_q <= 1'b1;
        end
        if (!valid_q[cmp_idx_q] && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
      if (ram_we) begin
        valid_q[free_idx_q] <= 1'b1;
      end
      if (finish) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= req_i.command;
      name_q   <= req_i.service_name;
      handle_q <= req_i.service_handle;
      owner_q  <= req_i.requester_id;
    end
    if (rd_en) begin
      cmp_idx_q <= rd_cnt_q[IDX_W-1:0];
    end
    if (cmp_vld_q) begin
      if (valid_q[cmp_idx_q] && (ram_rdata.name == name_q)) begin
        hit_handle_q <= ram_rdata.handle;
        hit_owner_q  <= ram_rdata.owner;
      end
      if (!valid_q[cmp_idx_q] && !free_found_q) begin
        free_idx_q <= cmp_idx_q;
      end
    end
    if (finish) begin
      rsp_handle_q <= '0;
      rsp_owner_q  <= '0;
      if (cmd_q == snr_pkg::CMD_REGISTER) begin
        rsp_status_q <= reg_ok ? snr_pkg::STATUS_REGISTERED : snr_pkg::STATUS_REG_FAILED;
      end else if (cmd_q == snr_pkg::CMD_LOOKUP) begin
        if (hit_q) begin
          rsp_status_q <= snr_pkg::STATUS_FOUND;
          rsp_handle_q <= hit_handle_q;
          rsp_owner_q  <= hit_owner_q;
        end else begin
          rsp_status_q <= snr_pkg::STATUS_NO_MATCH;
        end
      end else begin
        rsp_status_q <= snr_pkg::STATUS_BAD_COMMAND;
      end
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.found_handle = rsp_handle_q;
  assign rsp_o.found_owner  = rsp_owner_q;

  a_write_in_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == snr_pkg::ST_DONE))
    else $error("table write outside done state");

  a_write_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !valid_q[free_idx_q])
    else $error("table write over an occupied slot");

  a_rsp_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ($past(state_q) == snr_pkg::ST_DONE))
    else $error("result raised without a finished request");

  a_found_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_status_q == snr_pkg::STATUS_FOUND)) |-> (rsp_handle_q != 32'd0))
    else $error("found result with a zero handle");

endmodule

// ===== tb/sv/tb_service_name_registry_unit.sv =====
module tb_service_name_registry_unit;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 2 * (snr_pkg::TABLE_ENTRIES + 3) + 10;
  localparam int unsigned RANDOM_WORDS = 1150;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] name;
    logic [31:0] handle;
    logic [31:0] owner;
  } request_t;

  typedef struct packed {
    snr_pkg::status_e status;
    logic [31:0]      handle;
    logic [31:0]      owner;
  } reply_t;

  logic clk_i;
  logic rst_ni;

  snr_req_if req_if ();
  snr_rsp_if rsp_if ();

  service_name_registry_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow of the name table
  logic [31:0] tbl_name   [snr_pkg::TABLE_ENTRIES];
  logic [31:0] tbl_handle [snr_pkg::TABLE_ENTRIES];
  logic [31:0] tbl_owner  [snr_pkg::TABLE_ENTRIES];

  request_t    requests_pending[$];
  reply_t      replies_due[$];
  logic [31:0] names_tried[$];

  int unsigned words_queued;
  int unsigned words_taken;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned stress_phase;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  assign send_idle_pct = (stress_phase == 0) ? 13 : (stress_phase == 1) ? 45 : 0;
  assign recv_idle_pct = (stress_phase == 0) ? 45 : (stress_phase == 1) ? 13 : 0;

  function automatic int occupied_slot(logic [31:0] name);
    int slot;
    slot = -1;
    for (int i = snr_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (tbl_handle[i] != 32'd0 && tbl_name[i] == name) begin
        slot = i;
      end
    end
    return slot;
  endfunction

  function automatic reply_t registry_apply(request_t rq);
    reply_t rp;
    int     slot;
    int     free_slot;
    rp.status = snr_pkg::STATUS_BAD_COMMAND;
    rp.handle = 32'd0;
    rp.owner  = 32'd0;
    slot      = occupied_slot(rq.name);
    free_slot = -1;
    if (rq.command == snr_pkg::CMD_REGISTER) begin
      rp.status = snr_pkg::STATUS_REG_FAILED;
      for (int i = snr_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
        if (tbl_handle[i] == 32'd0) begin
          free_slot = i;
        end
      end
      if (rq.handle != 32'd0 && slot < 0 && free_slot >= 0) begin
        tbl_name[free_slot]   = rq.name;
        tbl_handle[free_slot] = rq.handle;
        tbl_owner[free_slot]  = rq.owner;
        rp.status = snr_pkg::STATUS_REGISTERED;
      end
    end else if (rq.command == snr_pkg::CMD_LOOKUP) begin
      if (slot >= 0) begin
        rp.status = snr_pkg::STATUS_FOUND;
        rp.handle = tbl_handle[slot];
        rp.owner  = tbl_owner[slot];
      end else begin
        rp.status = snr_pkg::STATUS_NO_MATCH;
      end
    end
    return rp;
  endfunction

  task automatic queue_request(logic [1:0] command, logic [31:0] name,
                               logic [31:0] handle, logic [31:0] owner);
    request_t rq;
    rq.command = command;
    rq.name    = name;
    rq.handle  = handle;
    rq.owner   = owner;
    requests_pending.push_back(rq);
    words_queued++;
    if (command == snr_pkg::CMD_REGISTER) begin
      names_tried.push_back(name);
    end
  endtask

  function automatic logic [31:0] pick_known_name();
    logic [31:0] name;
    name = $urandom;
    if (names_tried.size() > 0) begin
      name = names_tried[$urandom_range(names_tried.size() - 1)];
    end
    return name;
  endfunction

  task automatic queue_random_requests(int unsigned count);
    int unsigned pick;
    logic [31:0] handle;
    for (int unsigned n = 0; n < count; n++) begin
      pick   = $urandom_range(99);
      handle = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
      if (pick < 25) begin
        queue_request(snr_pkg::CMD_REGISTER, $urandom, handle, $urandom);
      end else if (pick < 35) begin
        queue_request(snr_pkg::CMD_REGISTER, pick_known_name(), $urandom | 32'd1, $urandom);
      end else if (pick < 70) begin
        queue_request(snr_pkg::CMD_LOOKUP, pick_known_name(), $urandom, $urandom);
      end else if (pick < 85) begin
        queue_request(snr_pkg::CMD_LOOKUP, $urandom, $urandom, $urandom);
      end else begin
        queue_request(($urandom_range(1) == 0) ? snr_pkg::CMD_SPARE0 : snr_pkg::CMD_SPARE1,
                      $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_service_name_registry_unit NOT OK");
    $finish;
  end

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        replies_due.push_back(registry_apply({req_if.command, req_if.service_name,
                                              req_if.service_handle, req_if.requester_id}));
        words_taken++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (requests_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid          <= 1'b1;
          req_if.command        <= requests_pending[0].command;
          req_if.service_name   <= requests_pending[0].name;
          req_if.service_handle <= requests_pending[0].handle;
          req_if.requester_id   <= requests_pending[0].owner;
          void'(requests_pending.pop_front());
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // reply monitor
  always @(posedge clk_i) begin
    reply_t exp_word;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t unexpected word: status %0d handle %h owner %h", $realtime,
                     rsp_if.status, rsp_if.found_handle, rsp_if.found_owner);
          end
        end else begin
          exp_word = replies_due.pop_front();
          if (rsp_if.status !== exp_word.status || rsp_if.found_handle !== exp_word.handle
              || rsp_if.found_owner !== exp_word.owner) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t mismatch: status %0d/%0d handle %h/%h owner %h/%h (exp/got)",
                       $realtime, exp_word.status, rsp_if.status, exp_word.handle,
                       rsp_if.found_handle, exp_word.owner, rsp_if.found_owner);
            end
          end
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    req_if.valid          = 1'b0;
    req_if.command        = snr_pkg::CMD_REGISTER;
    req_if.service_name   = 32'd0;
    req_if.service_handle = 32'd0;
    req_if.requester_id   = 32'd0;
    rsp_if.ready          = 1'b0;
    stress_phase          = 0;
    words_queued          = 0;
    words_taken           = 0;
    mismatches            = 0;
    cycle_count           = 0;
    for (int i = 0; i < snr_pkg::TABLE_ENTRIES; i++) begin
      tbl_name[i]   = 32'd0;
      tbl_handle[i] = 32'd0;
      tbl_owner[i]  = 32'd0;
    end

    // empty table, free slots hold name zero
    queue_request(snr_pkg::CMD_LOOKUP,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    queue_request(snr_pkg::CMD_LOOKUP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(snr_pkg::CMD_REGISTER, 32'h1234_5678, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(snr_pkg::CMD_LOOKUP,   32'h1234_5678, 32'h0000_0000, 32'h0000_0000);
    queue_request(snr_pkg::CMD_REGISTER, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
    queue_request(snr_pkg::CMD_LOOKUP,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    queue_request(snr_pkg::CMD_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(snr_pkg::CMD_LOOKUP,   32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    queue_request(snr_pkg::CMD_LOOKUP,   32'hFFFF_FFFE, 32'h0000_0000, 32'h0000_0000);
    // duplicate name, table unchanged
    queue_request(snr_pkg::CMD_REGISTER, 32'hFFFF_FFFF, 32'h0000_0005, 32'h0000_0007);
    queue_request(snr_pkg::CMD_LOOKUP,   32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    queue_request(snr_pkg::CMD_SPARE0,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(snr_pkg::CMD_SPARE1,   32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
    queue_request(snr_pkg::CMD_REGISTER, 32'h5555_AAAA, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(snr_pkg::CMD_LOOKUP,   32'h5555_AAAA, 32'h0000_0000, 32'h0000_0000);
    // fill the table and then try one more
    for (int i = 0; i < snr_pkg::TABLE_ENTRIES - 3; i++) begin
      queue_request(snr_pkg::CMD_REGISTER, 32'hA000_0000 + i, 32'h100 + i, 32'h200 + i);
    end
    queue_request(snr_pkg::CMD_REGISTER, 32'hB000_0000, 32'h0000_0009, 32'h0000_0003);
    queue_request(snr_pkg::CMD_LOOKUP, 32'hA000_0000 + snr_pkg::TABLE_ENTRIES - 4,
                  32'd0, 32'd0);

    queue_random_requests(RANDOM_WORDS / 3);
    while (requests_pending.size() != 0) @(negedge clk_i);
    stress_phase = 1;
    queue_random_requests(RANDOM_WORDS / 3);
    while (requests_pending.size() != 0) @(negedge clk_i);
    stress_phase = 2;
    queue_random_requests(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));

    while (words_taken != words_queued || replies_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_service_name_registry_unit OK");
    end else begin
      $display("tb_service_name_registry_unit NOT OK");
    end
    $finish;
  end

endmodule
